>>> design/ssh_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the stencil shear and heat flux block.
// Used by every module of the block; depends on nothing.
package ssh_pkg;

   // Number format
   localparam int DW     = 32;            // word width
   localparam int FB     = 16;            // fraction bits
   localparam int DIFF_W = DW + 1;        // difference of two words
   localparam int DIVN_W = DIFF_W + FB;   // scaled dividend magnitude
   localparam int REM_W  = DIFF_W + 1;    // divider partial remainder
   localparam int DCNT_W = $clog2(DIVN_W + 1);
   localparam int STEP_W = 4;

   typedef logic signed [DW-1:0]     word_type;
   typedef logic signed [DIFF_W-1:0] diff_type;

   localparam word_type W_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam word_type W_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [2*DW-1:0] P_MAX = (2*DW)'(W_MAX);
   localparam logic signed [2*DW-1:0] P_MIN = (2*DW)'(W_MIN);

   // Configuration register indexes and reset values
   localparam logic CSR_INV_RE_TAU    = 1'b0;
   localparam logic CSR_INV_RE_TAU_PR = 1'b1;
   localparam word_type INV_RE_TAU_RST    = DW'(655);
   localparam word_type INV_RE_TAU_PR_RST = DW'(917);

   typedef struct packed {
      word_type centre_pos;
      word_type visc_lam;
      word_type visc_turb;
      word_type velocity;
      word_type density;
      word_type diff_lam;
      word_type diff_turb;
      word_type enthalpy;
      word_type heat_cap;
      logic     last_cell;
   } cell_type;

   typedef struct packed {
      word_type shear_lam;
      word_type shear_turb;
      word_type heat_lam;
      word_type heat_turb;
      logic     last_result;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_T,
      ST_DIV_W,
      ST_DIV_G,
      ST_MUL,
      ST_EMIT
   } state_type;

   // floor((a + b) / 2); always within the word range
   function automatic word_type half_avg(input word_type a, input word_type b);
      diff_type s;
      s = diff_type'(a) + diff_type'(b);
      return s[DIFF_W-1:1];
   endfunction

   // Q product with floor shift and saturation
   function automatic word_type mul_q(input word_type a, input word_type b);
      logic signed [2*DW-1:0] p;
      logic signed [2*DW-1:0] s;
      p = (2*DW)'(a) * (2*DW)'(b);
      s = p >>> FB;
      if (s > P_MAX) return W_MAX;
      if (s < P_MIN) return W_MIN;
      return s[DW-1:0];
   endfunction

   // Difference of two words, one bit wider
   function automatic diff_type sub_w(input word_type a, input word_type b);
      return diff_type'(a) - diff_type'(b);
   endfunction

endpackage

>>> design/stencil_shear_and_heat_flux.sv
`timescale 1ns / 1ps
// Top level of the stencil shear and heat flux block: request queue, compute
// sequencer, configuration registers and response register. Depends on ssh_pkg,
// ssh_front and ssh_back.
//
// Cells go in through a queue interface in stream order, ghost cells included;
// each interior cell gives one response (four saturated Q16.16 fluxes) once the
// next cell has been taken, and last_cell closes the stream and clears the window.
// Each cell is processed on its own, by up to three divisions per cell running one
// quotient bit a cycle through a single shared serial divider, plus one shared
// 32x32 multiplier used for up to ten steps.
// A two-entry request queue and a one-entry response register let intake and
// draining proceed while a cell is being computed. Configuration writes are
// always accepted; write them only while the block is idle.
module stencil_shear_and_heat_flux (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              push,
   output logic              full,
   input  ssh_pkg::word_type req_centre_pos,
   input  ssh_pkg::word_type req_visc_lam,
   input  ssh_pkg::word_type req_visc_turb,
   input  ssh_pkg::word_type req_velocity,
   input  ssh_pkg::word_type req_density,
   input  ssh_pkg::word_type req_diff_lam,
   input  ssh_pkg::word_type req_diff_turb,
   input  ssh_pkg::word_type req_enthalpy,
   input  ssh_pkg::word_type req_heat_cap,
   input  logic              req_last_cell,
   // response channel
   output logic              empty,
   input  logic              pop,
   output ssh_pkg::word_type rsp_shear_lam,
   output ssh_pkg::word_type rsp_shear_turb,
   output ssh_pkg::word_type rsp_heat_lam,
   output ssh_pkg::word_type rsp_heat_turb,
   output logic              rsp_last_result,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  ssh_pkg::word_type csr_data
);
   import ssh_pkg::*;

   cell_type    push_cell, head_cell;
   logic        head_valid, head_pop;
   logic        res_valid, res_ready;
   result_type  res;
   result_type  out_ff;
   logic        out_valid_ff, out_valid_in;
   word_type    inv_re_tau_ff, inv_re_tau_in;
   word_type    inv_re_tau_pr_ff, inv_re_tau_pr_in;

   assign push_cell = '{
      centre_pos: req_centre_pos,
      visc_lam:   req_visc_lam,
      visc_turb:  req_visc_turb,
      velocity:   req_velocity,
      density:    req_density,
      diff_lam:   req_diff_lam,
      diff_turb:  req_diff_turb,
      enthalpy:   req_enthalpy,
      heat_cap:   req_heat_cap,
      last_cell:  req_last_cell
   };

   ssh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cell  (push_cell),
      .full       (full),
      .head_valid (head_valid),
      .head_cell  (head_cell),
      .head_pop   (head_pop)
   );

   ssh_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_cell     (head_cell),
      .head_pop      (head_pop),
      .inv_re_tau    (inv_re_tau_ff),
      .inv_re_tau_pr (inv_re_tau_pr_ff),
      .res_valid     (res_valid),
      .res           (res),
      .res_ready     (res_ready)
   );

   // Configuration register writes
   assign csr_ready = 1'b1;
   always_comb begin
      inv_re_tau_in    = inv_re_tau_ff;
      inv_re_tau_pr_in = inv_re_tau_pr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INV_RE_TAU:    inv_re_tau_in    = csr_data;
            CSR_INV_RE_TAU_PR: inv_re_tau_pr_in = csr_data;
            default: ;
         endcase
      end
   end

   // Response register: load when free or being drained
   assign res_ready = !out_valid_ff || pop;
   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff     <= 1'b0;
         inv_re_tau_ff    <= INV_RE_TAU_RST;
         inv_re_tau_pr_ff <= INV_RE_TAU_PR_RST;
      end else begin
         out_valid_ff     <= out_valid_in;
         inv_re_tau_ff    <= inv_re_tau_in;
         inv_re_tau_pr_ff <= inv_re_tau_pr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res;
      end
   end

   assign empty           = !out_valid_ff;
   assign rsp_shear_lam   = out_ff.shear_lam;
   assign rsp_shear_turb  = out_ff.shear_turb;
   assign rsp_heat_lam    = out_ff.heat_lam;
   assign rsp_heat_turb   = out_ff.heat_turb;
   assign rsp_last_result = out_ff.last_result;

endmodule

>>> design/ssh_div.sv
`timescale 1ns / 1ps
// Serial restoring divider: (num * 2^FB) / den, truncated toward zero, saturated.
// Depends on ssh_pkg.
module ssh_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ssh_pkg::diff_type num,
   input  ssh_pkg::diff_type den,
   output logic             done,
   output ssh_pkg::word_type quo
);
   import ssh_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [DIVN_W-1:0]   quo_ff, quo_in;
   logic [DIFF_W-1:0]   den_ff, den_in;
   logic                dz_ff, dz_in;
   logic                neg_ff, neg_in;
   logic                npos_ff, npos_in;
   logic                nneg_ff, nneg_in;

   logic [DIFF_W-1:0]   mag_num, mag_den;
   logic [REM_W-1:0]    trial;
   logic [REM_W:0]      trial_sub;
   logic [DIVN_W-1:0]   neg_q;

   // Magnitudes of the operands
   assign mag_num = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
   assign mag_den = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);

   // One quotient bit per cycle
   assign trial     = {rem_ff[REM_W-2:0], quo_ff[DIVN_W-1]};
   assign trial_sub = {1'b0, trial} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      dz_in   = dz_ff;
      neg_in  = neg_ff;
      npos_in = npos_ff;
      nneg_in = nneg_ff;
      if (start) begin
         neg_in  = num[DIFF_W-1] ^ den[DIFF_W-1];
         npos_in = !num[DIFF_W-1] && (num != '0);
         nneg_in = num[DIFF_W-1];
         if (den == '0) begin
            dz_in   = 1'b1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            dz_in   = 1'b0;
            busy_in = 1'b1;
            cnt_in  = DCNT_W'(DIVN_W);
            rem_in  = '0;
            quo_in  = {mag_num, {FB{1'b0}}};
            den_in  = mag_den;
         end
      end else if (busy_ff) begin
         if (!trial_sub[REM_W]) begin
            rem_in = trial_sub[REM_W-1:0];
         end else begin
            rem_in = trial;
         end
         quo_in = {quo_ff[DIVN_W-2:0], !trial_sub[REM_W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      dz_ff   <= dz_in;
      neg_ff  <= neg_in;
      npos_ff <= npos_in;
      nneg_ff <= nneg_in;
   end

   // Apply sign and saturate
   assign neg_q = -quo_ff;
   always_comb begin
      if (dz_ff) begin
         if (npos_ff) begin
            quo = W_MAX;
         end else if (nneg_ff) begin
            quo = W_MIN;
         end else begin
            quo = '0;
         end
      end else if (neg_ff) begin
         if (quo_ff > (DIVN_W'(1) << (DW-1))) begin
            quo = W_MIN;
         end else begin
            quo = neg_q[DW-1:0];
         end
      end else if (quo_ff > DIVN_W'(W_MAX)) begin
         quo = W_MAX;
      end else begin
         quo = quo_ff[DW-1:0];
      end
   end

   assign done = done_ff;

endmodule

>>> design/ssh_front.sv
`timescale 1ns / 1ps
// Front end: two-entry request queue that decouples intake from the compute sequencer.
// Depends on ssh_pkg.
module ssh_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ssh_pkg::cell_type push_cell,
   output logic             full,
   output logic             head_valid,
   output ssh_pkg::cell_type head_cell,
   input  logic             head_pop
);
   import ssh_pkg::*;

   cell_type    mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cell  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (head_pop && head_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      count_in = count_ff + 2'(do_push) - 2'(head_pop && head_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the request
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cell;
      end
   end

endmodule

>>> design/ssh_back.sv
`timescale 1ns / 1ps
// Back end: sequencer that runs the divisions for each cell and the shared multiplier once a
// previous cell is held, and keeps the stencil window. Depends on ssh_pkg and ssh_div.
module ssh_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  ssh_pkg::cell_type   head_cell,
   output logic               head_pop,
   input  ssh_pkg::word_type   inv_re_tau,
   input  ssh_pkg::word_type   inv_re_tau_pr,
   output logic               res_valid,
   output ssh_pkg::result_type res,
   input  logic               res_ready
);
   import ssh_pkg::*;

   localparam logic [STEP_W-1:0] STEP_F0  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_F1  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_P2  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_F2  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_P3  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_F3  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_R0  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_R1  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_R2  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_R3  = 4'd9;

   state_type           state_ff, state_in;
   logic [1:0]          seen_ff, seen_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   cell_type            prev_ff;
   word_type            pt_ff, t_ff, gw_ff, gt_ff, p_ff;
   word_type            f_ff   [4];
   word_type            pff_ff [4];
   word_type            r_ff   [4];

   logic                div_start, div_done;
   diff_type            div_num, div_den;
   word_type            div_q;
   word_type            mul_a, mul_b, mul_in;
   word_type            rho_h;
   logic                commit;
   cell_type            cur;

   assign cur = head_cell;

   ssh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_q)
   );

   // Select multiplier operands for the current step
   assign rho_h = half_avg(prev_ff.density, cur.density);
   always_comb begin
      case (step_ff)
         STEP_F0: begin
            mul_a = half_avg(prev_ff.visc_lam, cur.visc_lam);
            mul_b = gw_ff;
         end
         STEP_F1: begin
            mul_a = half_avg(prev_ff.visc_turb, cur.visc_turb);
            mul_b = gw_ff;
         end
         STEP_P2: begin
            mul_a = rho_h;
            mul_b = half_avg(prev_ff.diff_lam, cur.diff_lam);
         end
         STEP_F2, STEP_F3: begin
            mul_a = p_ff;
            mul_b = gt_ff;
         end
         STEP_P3: begin
            mul_a = rho_h;
            mul_b = half_avg(prev_ff.diff_turb, cur.diff_turb);
         end
         STEP_R0: begin
            mul_a = half_avg(pff_ff[0], f_ff[0]);
            mul_b = inv_re_tau;
         end
         STEP_R1: begin
            mul_a = half_avg(pff_ff[1], f_ff[1]);
            mul_b = inv_re_tau;
         end
         STEP_R2: begin
            mul_a = half_avg(pff_ff[2], f_ff[2]);
            mul_b = inv_re_tau_pr;
         end
         STEP_R3: begin
            mul_a = half_avg(pff_ff[3], f_ff[3]);
            mul_b = inv_re_tau;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_in = mul_q(mul_a, mul_b);

   // Next state and sequencer outputs
   always_comb begin
      state_in  = state_ff;
      seen_in   = seen_ff;
      step_in   = step_ff;
      div_start = 1'b0;
      div_num   = sub_w(cur.velocity, prev_ff.velocity);
      div_den   = sub_w(cur.centre_pos, prev_ff.centre_pos);
      commit    = 1'b0;
      res_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            div_num = diff_type'(cur.enthalpy);
            div_den = diff_type'(cur.heat_cap);
            if (head_valid) begin
               div_start = 1'b1;
               state_in  = ST_DIV_T;
            end
         end
         ST_DIV_T: begin
            if (div_done) begin
               if (seen_ff == 2'd0) begin
                  state_in = ST_EMIT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV_W;
               end
            end
         end
         ST_DIV_W: begin
            div_num = sub_w(t_ff, pt_ff);
            if (div_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV_G;
            end
         end
         ST_DIV_G: begin
            if (div_done) begin
               step_in  = STEP_F0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if ((step_ff == STEP_F3 && seen_ff == 2'd1) || step_ff == STEP_R3) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            res_valid = (seen_ff == 2'd2);
            if (seen_ff != 2'd2 || res_ready) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
               if (cur.last_cell) begin
                  seen_in = 2'd0;
               end else if (seen_ff == 2'd0) begin
                  seen_in = 2'd1;
               end else begin
                  seen_in = 2'd2;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign head_pop = commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         step_ff  <= step_in;
      end
   end

   // Capture quotients, products and the window
   always_ff @(posedge clock) begin
      if (div_done) begin
         case (state_ff)
            ST_DIV_T: t_ff  <= div_q;
            ST_DIV_W: gw_ff <= div_q;
            ST_DIV_G: gt_ff <= div_q;
            default: ;
         endcase
      end
      if (state_ff == ST_MUL) begin
         case (step_ff)
            STEP_F0: f_ff[0] <= mul_in;
            STEP_F1: f_ff[1] <= mul_in;
            STEP_P2, STEP_P3: p_ff <= mul_in;
            STEP_F2: f_ff[2] <= mul_in;
            STEP_F3: f_ff[3] <= mul_in;
            STEP_R0: r_ff[0] <= mul_in;
            STEP_R1: r_ff[1] <= mul_in;
            STEP_R2: r_ff[2] <= mul_in;
            STEP_R3: r_ff[3] <= mul_in;
            default: ;
         endcase
      end
      if (commit) begin
         prev_ff <= cur;
         pt_ff   <= t_ff;
         if (seen_ff != 2'd0) begin
            pff_ff <= f_ff;
         end
      end
   end

   assign res.shear_lam   = r_ff[0];
   assign res.shear_turb  = r_ff[1];
   assign res.heat_lam    = r_ff[2];
   assign res.heat_turb   = r_ff[3];
   assign res.last_result = cur.last_cell;

endmodule
